FILE: rtl/c_escape_unescaper_macros.svh
// Assertion helpers shared by cesc_engine and cesc_emit.
// Both expect clk and rst_n in scope.
`ifndef C_ESCAPE_UNESCAPER_MACROS_SVH
`define C_ESCAPE_UNESCAPER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define CESC_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CESC_IMPLY_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cesc_pkg.sv
package cesc_pkg;

    localparam int HOLD_DEPTH_DEF = 6;
    localparam int QUEUE_DEPTH    = 4;
    localparam int OCT_DIGITS     = 3;

    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_X      = 16'h0078;
    localparam logic [15:0] CH_U      = 16'h0075;
    localparam logic [7:0]  BYTE_BSL  = 8'h5C;
    localparam logic [7:0]  BYTE_QM   = 8'h3F;
    localparam logic [7:0]  BYTE_X    = 8'h78;
    localparam logic [7:0]  LATIN_MAX = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HIGH,
        PH_BACK,
        PH_OCT,
        PH_HEX1,
        PH_HEX2,
        PH_UNI
    } phase_t;

    // per-character classification, computed once at the front
    typedef struct packed {
        logic       bslash;
        logic       esc_hit;
        logic [7:0] esc_byte;
        logic       is_oct;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       is_x;
        logic       is_u;
        logic       is_high;
        logic       is_low;
    } cls_t;

    typedef struct packed {
        logic [15:0] ch;
        cls_t        cls;
    } hchar_t;

    typedef struct packed {
        logic [15:0] ch;
        cls_t        cls;
        logic        last;
    } req_t;

    // up to four bytes from one engine step; b[0] goes out first
    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
        logic            fin;
        logic            last;
    } rec_t;

    function automatic cls_t classify(input logic [15:0] c);
        cls_t r;
        r          = '0;
        r.bslash   = (c == CH_BSLASH);
        r.is_x     = (c == CH_X);
        r.is_u     = (c == CH_U);
        r.is_oct   = c inside {[16'h0030:16'h0037]};
        r.is_high  = c inside {[16'hD800:16'hDBFF]};
        r.is_low   = c inside {[16'hDC00:16'hDFFF]};
        if (c inside {[16'h0030:16'h0039]})
        begin
            r.hex_ok  = 1'b1;
            r.hex_val = c[3:0];
        end
        else if (c inside {[16'h0041:16'h0046], [16'h0061:16'h0066]})
        begin
            r.hex_ok  = 1'b1;
            r.hex_val = c[3:0] + 4'd9;
        end
        r.esc_hit = 1'b1;
        case (c)
            16'h0061: r.esc_byte = 8'h07;   // a
            16'h0062: r.esc_byte = 8'h08;   // b
            16'h0065: r.esc_byte = 8'h1B;   // e
            16'h0066: r.esc_byte = 8'h0C;   // f
            16'h006E: r.esc_byte = 8'h0A;   // n
            16'h0072: r.esc_byte = 8'h0D;   // r
            16'h0074: r.esc_byte = 8'h09;   // t
            16'h0076: r.esc_byte = 8'h0B;   // v
            16'h005C: r.esc_byte = 8'h5C;   // backslash
            16'h0027: r.esc_byte = 8'h27;   // single quote
            16'h0022: r.esc_byte = 8'h22;   // double quote
            16'h003F: r.esc_byte = 8'h3F;   // question mark
            default:
            begin
                r.esc_hit  = 1'b0;
                r.esc_byte = 8'h00;
            end
        endcase
        return r;
    endfunction

    // one character to UTF-8 or Latin-1 bytes
    function automatic rec_t encode(input logic [15:0] u, input logic utf8);
        rec_t r;
        r = '0;
        if (!utf8)
        begin
            r.n    = 3'd1;
            r.b[0] = (u <= {8'h00, LATIN_MAX}) ? u[7:0] : BYTE_QM;
        end
        else if (u < 16'h0080)
        begin
            r.n    = 3'd1;
            r.b[0] = u[7:0];
        end
        else if (u < 16'h0800)
        begin
            r.n    = 3'd2;
            r.b[0] = {3'b110, u[10:6]};
            r.b[1] = {2'b10, u[5:0]};
        end
        else if (u inside {[16'hD800:16'hDFFF]})
        begin
            r.n    = 3'd1;
            r.b[0] = BYTE_QM;
        end
        else
        begin
            r.n    = 3'd3;
            r.b[0] = {4'hE, u[15:12]};
            r.b[1] = {2'b10, u[11:6]};
            r.b[2] = {2'b10, u[5:0]};
        end
        return r;
    endfunction

endpackage

FILE: rtl/cesc_front.sv
module cesc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       char_unit,
    input  logic              text_last,
    input  logic              head_pop,
    output logic              head_valid,
    output cesc_pkg::req_t    head
);

    localparam int QW    = $clog2(cesc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = QW + 1;

    cesc_pkg::req_t   q_reg [cesc_pkg::QUEUE_DEPTH];
    logic [QW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;
    cesc_pkg::req_t   wr_data;

    assign in_ready   = (cnt_reg != CNT_W'(cesc_pkg::QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (cnt_reg != '0);
    assign pop        = head_pop && head_valid;
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_data.ch   = char_unit;
        wr_data.cls  = cesc_pkg::classify(char_unit);
        wr_data.last = text_last;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/cesc_engine.sv
`include "c_escape_unescaper_macros.svh"

module cesc_engine #(
    parameter int HOLD_DEPTH = cesc_pkg::HOLD_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              utf8,
    input  logic              head_valid,
    input  cesc_pkg::req_t    head,
    output logic              head_pop,
    input  logic              stg_free,
    output logic              rec_we,
    output cesc_pkg::rec_t    rec
);

    localparam int IDX_W = $clog2(HOLD_DEPTH);
    localparam int HC_W  = $clog2(HOLD_DEPTH + 1);

    cesc_pkg::phase_t phase_reg, phase_next;
    logic [HC_W-1:0]  hc_reg, hc_next;
    logic [7:0]       acc_reg, acc_next;
    logic [HC_W-1:0]  rp_reg, rp_next;
    logic [HC_W-1:0]  rend_reg, rend_next;
    logic             ilast_reg, ilast_next;
    cesc_pkg::hchar_t held_reg [HOLD_DEPTH];

    logic              hw_en;
    logic [IDX_W-1:0]  hw_idx;
    cesc_pkg::hchar_t  hw_data;

    logic              seg_act;
    logic [15:0]       cur_ch;
    cesc_pkg::cls_t    cur_cls;
    logic              cur_l;
    logic              item_last;
    logic              go;
    logic              reproc;
    logic              new_seg;
    logic [HC_W-1:0]   hc_inc;
    logic [7:0]        oct_acc;
    logic [15:0]       uni_v;
    logic              uni_ok;
    logic [10:0]       pair_hi;
    logic [20:0]       pair_cp;
    cesc_pkg::rec_t    enc_cur;
    cesc_pkg::rec_t    enc_uni;
    cesc_pkg::cls_t    dig_cls;

    // replay segment held[rp..rend-1] runs ahead of the queue head
    assign seg_act   = (rp_reg < rend_reg);
    assign cur_ch    = seg_act ? held_reg[rp_reg[IDX_W-1:0]].ch  : head.ch;
    assign cur_cls   = seg_act ? held_reg[rp_reg[IDX_W-1:0]].cls : head.cls;
    assign item_last = seg_act ? ilast_reg : head.last;
    assign cur_l     = seg_act ? (ilast_reg && (rp_reg == rend_reg - HC_W'(1))) : head.last;
    assign go        = (seg_act || head_valid) && stg_free;

    assign hc_inc    = hc_reg + HC_W'(1);
    assign oct_acc   = {acc_reg[4:0], cur_ch[2:0]};
    assign pair_hi   = {1'b0, held_reg[0].ch[9:0]} + 11'h040;
    assign pair_cp   = {pair_hi, cur_ch[9:0]};
    assign enc_cur   = cesc_pkg::encode(cur_ch, utf8);
    assign enc_uni   = cesc_pkg::encode(uni_v, utf8);

    // \u digits: held[2..HOLD_DEPTH-2] plus the character arriving now
    always_comb
    begin
        uni_v  = '0;
        uni_ok = 1'b1;
        for (int i = 2; i < HOLD_DEPTH; i++)
        begin
            dig_cls = (i == HOLD_DEPTH - 1) ? cur_cls : held_reg[i].cls;
            uni_ok  = uni_ok && dig_cls.hex_ok;
            uni_v   = {uni_v[11:0], dig_cls.hex_val};
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        hc_next    = hc_reg;
        acc_next   = acc_reg;
        rp_next    = rp_reg;
        rend_next  = rend_reg;
        ilast_next = ilast_reg;
        hw_en      = 1'b0;
        hw_idx     = '0;
        hw_data    = '{ch: cur_ch, cls: cur_cls};
        reproc     = 1'b0;
        new_seg    = 1'b0;
        head_pop   = 1'b0;
        rec_we     = 1'b0;
        rec        = '0;

        if (go)
        begin
            case (phase_reg)
                cesc_pkg::PH_HIGH:
                begin
                    phase_next = cesc_pkg::PH_IDLE;
                    hc_next    = '0;
                    acc_next   = '0;
                    if (utf8 && cur_cls.is_low)
                    begin
                        rec.n    = 3'd4;
                        rec.b[0] = {5'b11110, pair_cp[20:18]};
                        rec.b[1] = {2'b10, pair_cp[17:12]};
                        rec.b[2] = {2'b10, pair_cp[11:6]};
                        rec.b[3] = {2'b10, pair_cp[5:0]};
                    end
                    else
                    begin
                        // held high surrogate alone always encodes as '?'
                        rec.n    = 3'd1;
                        rec.b[0] = cesc_pkg::BYTE_QM;
                        reproc   = 1'b1;
                    end
                end
                cesc_pkg::PH_BACK:
                begin
                    phase_next = cesc_pkg::PH_IDLE;
                    hc_next    = '0;
                    acc_next   = '0;
                    if (cur_cls.esc_hit)
                    begin
                        rec.n    = 3'd1;
                        rec.b[0] = cur_cls.esc_byte;
                    end
                    else if (cur_cls.is_oct)
                    begin
                        if (cur_l)
                        begin
                            rec.n    = 3'd1;
                            rec.b[0] = {5'd0, cur_ch[2:0]};
                        end
                        else
                        begin
                            phase_next = cesc_pkg::PH_OCT;
                            acc_next   = {5'd0, cur_ch[2:0]};
                            hc_next    = HC_W'(1);
                        end
                    end
                    else if (cur_cls.is_x || cur_cls.is_u)
                    begin
                        if (cur_l)
                        begin
                            rec.n    = 3'd2;
                            rec.b[0] = cesc_pkg::BYTE_BSL;
                            rec.b[1] = cur_ch[7:0];
                        end
                        else
                        begin
                            // the backslash is not stored in slot 0; a replay starts at slot 1
                            phase_next = cur_cls.is_x ? cesc_pkg::PH_HEX1 : cesc_pkg::PH_UNI;
                            hw_en      = 1'b1;
                            hw_idx     = IDX_W'(1);
                            hc_next    = HC_W'(2);
                        end
                    end
                    else
                    begin
                        rec.n    = 3'd1;
                        rec.b[0] = cesc_pkg::BYTE_BSL;
                        reproc   = 1'b1;
                    end
                end
                cesc_pkg::PH_OCT:
                begin
                    if (cur_cls.is_oct)
                    begin
                        acc_next = oct_acc;
                        hc_next  = hc_inc;
                        if ((hc_inc >= HC_W'(cesc_pkg::OCT_DIGITS)) || cur_l)
                        begin
                            rec.n      = 3'd1;
                            rec.b[0]   = oct_acc;
                            phase_next = cesc_pkg::PH_IDLE;
                            hc_next    = '0;
                            acc_next   = '0;
                        end
                    end
                    else
                    begin
                        rec.n      = 3'd1;
                        rec.b[0]   = acc_reg;
                        phase_next = cesc_pkg::PH_IDLE;
                        hc_next    = '0;
                        acc_next   = '0;
                        reproc     = 1'b1;
                    end
                end
                cesc_pkg::PH_HEX1:
                begin
                    if (cur_cls.hex_ok)
                    begin
                        if (cur_l)
                        begin
                            rec.n      = 3'd1;
                            rec.b[0]   = {4'd0, cur_cls.hex_val};
                            phase_next = cesc_pkg::PH_IDLE;
                            hc_next    = '0;
                            acc_next   = '0;
                        end
                        else
                        begin
                            acc_next   = {4'd0, cur_cls.hex_val};
                            phase_next = cesc_pkg::PH_HEX2;
                        end
                    end
                    else
                    begin
                        // backslash dropped: the 'x' goes out as a plain byte, this char is reprocessed
                        rec.n      = 3'd1;
                        rec.b[0]   = cesc_pkg::BYTE_X;
                        phase_next = cesc_pkg::PH_IDLE;
                        hc_next    = '0;
                        acc_next   = '0;
                        reproc     = 1'b1;
                    end
                end
                cesc_pkg::PH_HEX2:
                begin
                    rec.n      = 3'd1;
                    phase_next = cesc_pkg::PH_IDLE;
                    hc_next    = '0;
                    acc_next   = '0;
                    if (cur_cls.hex_ok)
                    begin
                        rec.b[0] = {acc_reg[3:0], cur_cls.hex_val};
                    end
                    else
                    begin
                        rec.b[0] = acc_reg;
                        reproc   = 1'b1;
                    end
                end
                cesc_pkg::PH_UNI:
                begin
                    hw_en   = 1'b1;
                    hw_idx  = hc_reg[IDX_W-1:0];
                    hc_next = hc_inc;
                    if (hc_inc == HC_W'(HOLD_DEPTH))
                    begin
                        phase_next = cesc_pkg::PH_IDLE;
                        hc_next    = '0;
                        acc_next   = '0;
                        if (uni_ok)
                        begin
                            rec.n = enc_uni.n;
                            rec.b = enc_uni.b;
                        end
                        else
                        begin
                            new_seg   = 1'b1;
                            rend_next = HC_W'(HOLD_DEPTH);
                        end
                    end
                    else if (cur_l)
                    begin
                        rec.n      = 3'd1;
                        rec.b[0]   = cesc_pkg::BYTE_BSL;
                        phase_next = cesc_pkg::PH_IDLE;
                        hc_next    = '0;
                        acc_next   = '0;
                        new_seg    = 1'b1;
                        rend_next  = hc_inc;
                    end
                end
                default:
                begin
                    phase_next = cesc_pkg::PH_IDLE;
                    hc_next    = '0;
                    acc_next   = '0;
                    if (cur_cls.bslash)
                    begin
                        if (cur_l)
                        begin
                            rec.n    = 3'd1;
                            rec.b[0] = cesc_pkg::BYTE_BSL;
                        end
                        else
                        begin
                            phase_next = cesc_pkg::PH_BACK;
                            hc_next    = HC_W'(1);
                        end
                    end
                    else if (utf8 && cur_cls.is_high && !cur_l)
                    begin
                        phase_next = cesc_pkg::PH_HIGH;
                        hw_en      = 1'b1;
                        hw_idx     = '0;
                        hc_next    = HC_W'(1);
                    end
                    else
                    begin
                        rec.n = enc_cur.n;
                        rec.b = enc_cur.b;
                    end
                end
            endcase

            if (!reproc)
            begin
                if (seg_act)
                begin
                    rp_next = rp_reg + HC_W'(1);
                end
                else
                begin
                    head_pop   = 1'b1;
                    ilast_next = head.last;
                end
            end
            if (new_seg)
            begin
                rp_next = HC_W'(1);
            end

            rec.fin  = !reproc && !new_seg &&
                       (!seg_act || (rp_reg == rend_reg - HC_W'(1)));
            rec.last = item_last;
            rec_we   = (rec.n != 3'd0) || rec.fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cesc_pkg::PH_IDLE;
            hc_reg    <= '0;
            acc_reg   <= '0;
            rp_reg    <= '0;
            rend_reg  <= '0;
            ilast_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            acc_reg   <= acc_next;
            rp_reg    <= rp_next;
            rend_reg  <= rend_next;
            ilast_reg <= ilast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            held_reg[hw_idx] <= hw_data;
        end
    end

    `CESC_CHECK(a_hc_bound, hc_reg < HC_W'(HOLD_DEPTH), "held count reached hold depth")
    `CESC_CHECK(a_no_pop_in_seg, !(head_pop && seg_act), "queue popped during replay")
    `CESC_CHECK(a_high_held, (phase_reg != cesc_pkg::PH_HIGH) || held_reg[0].cls.is_high, "held unit is not a high surrogate")
    `CESC_IMPLY_NEXT(a_reproc_idle, go && reproc, phase_reg == cesc_pkg::PH_IDLE, "reprocess left escape pending")

endmodule

FILE: rtl/cesc_emit.sv
`include "c_escape_unescaper_macros.svh"

module cesc_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rec_we,
    input  cesc_pkg::rec_t    rec,
    output logic              stg_free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              run_last,
    output logic              text_end
);

    cesc_pkg::rec_t stg_reg, stg_next;
    logic           stg_valid_reg, stg_valid_next;
    logic [2:0]     idx_reg, idx_next;
    logic [7:0]     tail_reg, tail_next;
    logic           tail_valid_reg, tail_valid_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_byte_reg, out_byte_next;
    logic           run_last_reg, run_last_next;
    logic           text_end_reg, text_end_next;

    logic           can_out;
    logic           have_byte;
    logic [7:0]     byte_cur;
    logic           done;

    assign can_out   = !out_valid_reg || out_ready;
    assign have_byte = stg_valid_reg && (idx_reg < stg_reg.n);
    assign byte_cur  = stg_reg.b[idx_reg[1:0]];

    // the newest byte waits in the tail until we know whether it ends the request
    always_comb
    begin
        stg_next        = stg_reg;
        stg_valid_next  = stg_valid_reg;
        idx_next        = idx_reg;
        tail_next       = tail_reg;
        tail_valid_next = tail_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        run_last_next   = run_last_reg;
        text_end_next   = text_end_reg;
        done            = 1'b0;

        if (have_byte)
        begin
            if (!tail_valid_reg)
            begin
                tail_next       = byte_cur;
                tail_valid_next = 1'b1;
                idx_next        = idx_reg + 3'd1;
            end
            else if (can_out)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = tail_reg;
                run_last_next  = 1'b0;
                text_end_next  = 1'b0;
                tail_next      = byte_cur;
                idx_next       = idx_reg + 3'd1;
            end
        end
        else if (stg_valid_reg)
        begin
            if (stg_reg.fin && tail_valid_reg)
            begin
                if (can_out)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = tail_reg;
                    run_last_next   = 1'b1;
                    text_end_next   = stg_reg.last;
                    tail_valid_next = 1'b0;
                    done            = 1'b1;
                end
            end
            else
            begin
                done = 1'b1;
            end
        end

        if (done)
        begin
            stg_valid_next = 1'b0;
            idx_next       = '0;
        end
        if (rec_we)
        begin
            stg_next       = rec;
            stg_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    assign stg_free  = !stg_valid_reg || done;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign text_end  = text_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            tail_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            stg_valid_reg  <= stg_valid_next;
            idx_reg        <= idx_next;
            tail_valid_reg <= tail_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_reg      <= stg_next;
        tail_reg     <= tail_next;
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
        text_end_reg <= text_end_next;
    end

    `CESC_CHECK(a_tail_behind, !(out_valid_reg && !run_last_reg) || tail_valid_reg, "non-final byte shown with empty tail")
    `CESC_CHECK(a_idx_bound, !stg_valid_reg || (idx_reg <= stg_reg.n), "byte index past record")
    `CESC_CHECK(a_stg_overrun, !(rec_we && !stg_free), "record written over busy staging")

endmodule

FILE: rtl/c_escape_unescaper.sv
// C escape-sequence decoder. Each request carries one 16-bit character
// (char_unit) and text_last, which closes the text and forces every pending
// decision. Results are bytes: plain characters come out as UTF-8 or as
// Latin-1 ('?' for anything above 0xFF), set by the one-bit register written
// through cfg_we/cfg_wdata (resets to UTF-8). Escapes \a \b \e \f \n \r \t
// \v \\ \' \" \?, octal (1-3 digits), \x (1-2 hex digits) and \u (exactly 4
// hex digits) are decoded; an escape that needs later characters is held.
// run_last flags the last byte a request caused and text_end the last byte
// of the text; a request that causes no bytes gives no result. Timing: a
// front queue of four classified requests takes one request per cycle while
// it has room. The back engine handles one character per cycle while the
// emitter can take its record, and each replayed character needs an engine
// step of its own (a failed \u replays up to five, a failed \x or unknown
// escape one). Bytes drain through the emitter at one per cycle while
// out_ready allows; the emitter takes a new record only as it finishes the
// one it holds. The emitter's byte rate sets the sustained throughput.
module c_escape_unescaper #(
    parameter int HOLD_DEPTH = cesc_pkg::HOLD_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] char_unit,
    input  logic        text_last,
    // byte channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        text_end,
    // encoding_mode: 0 Latin-1, 1 UTF-8
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic           enc_mode_reg;
    logic           enc_mode_next;

    logic           head_valid;
    logic           head_pop;
    cesc_pkg::req_t head;
    logic           stg_free;
    logic           rec_we;
    cesc_pkg::rec_t rec;

    assign enc_mode_next = cfg_we ? cfg_wdata : enc_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_mode_reg <= 1'b1;
        end
        else
        begin
            enc_mode_reg <= enc_mode_next;
        end
    end

    // front: accept and classify, short request queue
    cesc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_unit  (char_unit),
        .text_last  (text_last),
        .head_pop   (head_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: escape state machine with hold buffer and replay
    cesc_engine #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .utf8       (enc_mode_reg),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .stg_free   (stg_free),
        .rec_we     (rec_we),
        .rec        (rec)
    );

    // byte serializer, end-of-request marking, output register
    cesc_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_we     (rec_we),
        .rec        (rec),
        .stg_free   (stg_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .text_end   (text_end)
    );

endmodule
